### src/c8reu_pkg.sv
// Shared types, codes, microprogram and helper functions of the CHIP-8 execute unit.
package c8reu_pkg;

  localparam int REG_COUNT = 16;
  localparam int REG_W     = 8;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int INDEX_W   = 16;
  localparam int KEY_COUNT = 16;
  localparam int ADDR_W    = 12;
  localparam int UPC_W     = 4;

  localparam logic [INDEX_W-1:0] FONT_BYTES = 16'd5;
  localparam logic [REG_IDX_W-1:0] FLAG_REG = 4'hF;

  // instruction groups
  localparam logic [1:0] CMD_ALU  = 2'd0;
  localparam logic [1:0] CMD_KEY  = 2'd1;
  localparam logic [1:0] CMD_MISC = 2'd2;

  // 8xyN function codes
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_RSUB = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // ExKK codes
  localparam logic [7:0] K_SKIP_DOWN = 8'h9E;
  localparam logic [7:0] K_SKIP_UP   = 8'hA1;

  // FxKK codes
  localparam logic [7:0] F_GET_DELAY = 8'h07;
  localparam logic [7:0] F_WAIT_KEY  = 8'h0A;
  localparam logic [7:0] F_SET_DELAY = 8'h15;
  localparam logic [7:0] F_SET_SOUND = 8'h18;
  localparam logic [7:0] F_ADD_INDEX = 8'h1E;
  localparam logic [7:0] F_FONT      = 8'h29;
  localparam logic [7:0] F_BCD       = 8'h33;
  localparam logic [7:0] F_STORE     = 8'h55;
  localparam logic [7:0] F_LOAD      = 8'h65;

  // program-counter steps
  localparam logic [1:0] STEP_WAIT = 2'd0;
  localparam logic [1:0] STEP_NEXT = 2'd1;
  localparam logic [1:0] STEP_SKIP = 2'd2;

  // register file read address select
  localparam logic [1:0] RD_IN_Y = 2'd0;
  localparam logic [1:0] RD_X    = 2'd1;
  localparam logic [1:0] RD_CNT  = 2'd2;

  // register file write select
  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_ALU   = 2'd1;
  localparam logic [1:0] WR_FLAG  = 2'd2;
  localparam logic [1:0] WR_FMISC = 2'd3;

  // result word kinds
  localparam logic [2:0] EM_NONE   = 3'd0;
  localparam logic [2:0] EM_SINGLE = 3'd1;
  localparam logic [2:0] EM_BCD0   = 3'd2;
  localparam logic [2:0] EM_BCD1   = 3'd3;
  localparam logic [2:0] EM_BCD2   = 3'd4;
  localparam logic [2:0] EM_STORE  = 3'd5;

  // sequencer next-step kinds
  localparam logic [2:0] NX_SEQ      = 3'd0;
  localparam logic [2:0] NX_GOTO     = 3'd1;
  localparam logic [2:0] NX_DISPATCH = 3'd2;
  localparam logic [2:0] NX_FLAG     = 3'd3;
  localparam logic [2:0] NX_LOOP     = 3'd4;

  // microprogram addresses
  localparam logic [UPC_W-1:0] U_IDLE  = 4'd0;
  localparam logic [UPC_W-1:0] U_RDX   = 4'd1;
  localparam logic [UPC_W-1:0] U_DISP  = 4'd2;
  localparam logic [UPC_W-1:0] U_ALU   = 4'd3;
  localparam logic [UPC_W-1:0] U_EMIT  = 4'd4;
  localparam logic [UPC_W-1:0] U_FLAG  = 4'd5;
  localparam logic [UPC_W-1:0] U_FMISC = 4'd6;
  localparam logic [UPC_W-1:0] U_BCD0  = 4'd7;
  localparam logic [UPC_W-1:0] U_BCD1  = 4'd8;
  localparam logic [UPC_W-1:0] U_BCD2  = 4'd9;
  localparam logic [UPC_W-1:0] U_STRD  = 4'd10;
  localparam logic [UPC_W-1:0] U_STEM  = 4'd11;
  localparam logic [UPC_W-1:0] U_STIX  = 4'd12;

  typedef struct packed {
    logic             wait_in;
    logic [1:0]       rd_sel;
    logic             ld_a;
    logic             ld_b;
    logic             cnt_clr;
    logic             cnt_inc;
    logic [1:0]       wr_sel;
    logic             fmisc;
    logic             idx_add_x;
    logic [2:0]       emit;
    logic [2:0]       nxt;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] sub;
    logic       flag_op;
    logic       store_last;
    logic       out_free;
  } stat_t;

  function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] upc);
    ctrl_t c;
    c = '0;
    c.rd_sel = RD_X;
    c.nxt    = NX_GOTO;
    c.target = U_IDLE;
    case (upc)
      U_IDLE: begin
        c.wait_in = 1'b1;
        c.rd_sel  = RD_IN_Y;
        c.nxt     = NX_SEQ;
      end
      U_RDX: begin
        c.ld_b = 1'b1;
        c.nxt  = NX_SEQ;
      end
      U_DISP: begin
        c.ld_a    = 1'b1;
        c.cnt_clr = 1'b1;
        c.nxt     = NX_DISPATCH;
      end
      U_ALU: begin
        c.wr_sel = WR_ALU;
        c.nxt    = NX_FLAG;
        c.target = U_FLAG;
      end
      U_EMIT: begin
        c.emit = EM_SINGLE;
      end
      U_FLAG: begin
        c.wr_sel = WR_FLAG;
        c.emit   = EM_SINGLE;
      end
      U_FMISC: begin
        c.wr_sel = WR_FMISC;
        c.fmisc  = 1'b1;
        c.emit   = EM_SINGLE;
      end
      U_BCD0: begin
        c.emit = EM_BCD0;
        c.nxt  = NX_SEQ;
      end
      U_BCD1: begin
        c.emit = EM_BCD1;
        c.nxt  = NX_SEQ;
      end
      U_BCD2: begin
        c.emit = EM_BCD2;
      end
      U_STRD: begin
        c.rd_sel = RD_CNT;
        c.nxt    = NX_SEQ;
      end
      U_STEM: begin
        c.rd_sel  = RD_CNT;
        c.emit    = EM_STORE;
        c.cnt_inc = 1'b1;
        c.nxt     = NX_LOOP;
        c.target  = U_STRD;
      end
      U_STIX: begin
        c.idx_add_x = 1'b1;
      end
      default: begin
        c.nxt = NX_GOTO;
      end
    endcase
    return c;
  endfunction

  function automatic logic [UPC_W-1:0] dispatch(input logic [1:0] cmd, input logic [7:0] sub);
    logic [UPC_W-1:0] t;
    t = U_EMIT;
    case (cmd)
      CMD_ALU: t = U_ALU;
      CMD_MISC: begin
        case (sub)
          F_BCD:   t = U_BCD0;
          F_STORE: t = U_STRD;
          default: t = U_FMISC;
        endcase
      end
      default: t = U_EMIT;
    endcase
    return t;
  endfunction

  // {hundreds, tens, ones}, tens by reciprocal multiply (exact below 1029)
  function automatic logic [11:0] bcd_digits(input logic [7:0] v);
    logic [1:0]  h;
    logic [6:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  o;
    if (v >= 8'd200) begin
      h = 2'd2;
      r = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      h = 2'd1;
      r = 7'(v - 8'd100);
    end else begin
      h = 2'd0;
      r = v[6:0];
    end
    p = 15'(r) * 15'd205;
    t = p[14:11];
    o = r - 7'(7'(t) * 7'd10);
    return {2'b00, h, t, o[3:0]};
  endfunction

endpackage

### src/c8reu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module c8reu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### src/c8reu_seq.sv
// Microprogram sequencer: step counter, control store lookup and next-step selection.
module c8reu_seq import c8reu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  go
);

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;

  assign ctrl     = ucode_rom(upc_r);
  assign in_stall = !ctrl.wait_in;
  // a step holds until its input word arrives and its result slot is free
  assign go = (!ctrl.wait_in || in_valid) && ((ctrl.emit == EM_NONE) || stat.out_free);

  always_comb begin
    upc_nxt = upc_r;
    if (go) begin
      case (ctrl.nxt)
        NX_SEQ:      upc_nxt = upc_r + 1'b1;
        NX_GOTO:     upc_nxt = ctrl.target;
        NX_DISPATCH: upc_nxt = dispatch(stat.cmd, stat.sub);
        NX_FLAG:     upc_nxt = stat.flag_op ? ctrl.target : upc_r + 1'b1;
        NX_LOOP:     upc_nxt = stat.store_last ? upc_r + 1'b1 : ctrl.target;
        default:     upc_nxt = U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

### src/c8reu_dp.sv
// Datapath: register file, index and timer registers, ALU, BCD and the result register.
module c8reu_dp import c8reu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           in_command,
  input  logic [7:0]           in_sub_op,
  input  logic [REG_IDX_W-1:0] in_reg_x,
  input  logic [REG_IDX_W-1:0] in_reg_y,
  input  logic [KEY_COUNT-1:0] in_keypad,
  input  ctrl_t                ctrl,
  input  logic                 go,
  output stat_t                stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_mem_write,
  output logic [ADDR_W-1:0]    out_mem_address,
  output logic [7:0]           out_mem_data,
  output logic [1:0]           out_pc_step,
  output logic                 out_last
);

  logic                 accept;
  logic [1:0]           cmd_r;
  logic [7:0]           sub_r;
  logic [REG_IDX_W-1:0] x_r;
  logic [KEY_COUNT-1:0] key_r;
  logic [REG_W-1:0]     a_r;
  logic [REG_W-1:0]     b_r;
  logic [REG_IDX_W-1:0] cnt_r;
  logic [REG_IDX_W-1:0] cnt_nxt;
  logic [INDEX_W-1:0]   index_r;
  logic [INDEX_W-1:0]   index_nxt;
  logic [REG_W-1:0]     delay_r;
  logic [REG_W-1:0]     delay_nxt;
  logic [REG_W-1:0]     sound_r;
  logic [REG_W-1:0]     sound_nxt;
  logic [REG_COUNT-1:0] vld_r;
  logic [REG_COUNT-1:0] vld_nxt;
  logic                 rd_vld_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;

  logic [REG_IDX_W-1:0] raddr;
  logic [REG_W-1:0]     ram_q;
  logic [REG_W-1:0]     rd_val;
  logic                 we;
  logic [REG_IDX_W-1:0] waddr;
  logic [REG_W-1:0]     wdata;

  logic [REG_W:0]       sum9;
  logic [REG_W-1:0]     alu_res;
  logic                 alu_flag;
  logic                 alu_wr;
  logic                 any_key;
  logic [REG_IDX_W-1:0] low_key;
  logic                 key_down;
  logic [1:0]           single_step;
  logic                 store_last;
  logic                 out_free;
  logic [11:0]          bcd;

  logic                 o_wr;
  logic [REG_IDX_W-1:0] o_off;
  logic [7:0]           o_data;
  logic [1:0]           o_step;
  logic                 o_last;
  logic [INDEX_W-1:0]   addr_sum;

  assign accept = go && ctrl.wait_in;

  // register file read port
  always_comb begin
    case (ctrl.rd_sel)
      RD_IN_Y: raddr = in_reg_y;
      RD_CNT:  raddr = cnt_r;
      default: raddr = x_r;
    endcase
  end

  c8reu_ram #(
    .WIDTH(REG_W),
    .DEPTH(REG_COUNT)
  ) u_regs (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(ram_q)
  );

  // never-written registers read as zero
  assign rd_val = rd_vld_r ? ram_q : '0;

  // ALU, a = Vx and b = Vy as read before the instruction
  assign sum9 = {1'b0, a_r} + {1'b0, b_r};

  always_comb begin
    alu_res  = b_r;
    alu_flag = 1'b0;
    alu_wr   = 1'b1;
    case (sub_r[3:0])
      ALU_MOV: alu_res = b_r;
      ALU_OR:  alu_res = a_r | b_r;
      ALU_AND: alu_res = a_r & b_r;
      ALU_XOR: alu_res = a_r ^ b_r;
      ALU_ADD: begin
        alu_res  = sum9[REG_W-1:0];
        alu_flag = sum9[REG_W];
      end
      ALU_SUB: begin
        alu_res  = a_r - b_r;
        alu_flag = (a_r >= b_r);
      end
      ALU_SHR: begin
        alu_res  = b_r >> 1;
        alu_flag = a_r[0];
      end
      ALU_RSUB: begin
        alu_res  = b_r - a_r;
        alu_flag = (b_r >= a_r);
      end
      ALU_SHL: begin
        alu_res  = b_r << 1;
        alu_flag = a_r[REG_W-1];
      end
      default: alu_wr = 1'b0;
    endcase
  end

  // keys
  assign any_key = |key_r;

  always_comb begin
    low_key = '0;
    for (int i = KEY_COUNT - 1; i >= 0; i--) begin
      if (key_r[i]) begin
        low_key = REG_IDX_W'(i);
      end
    end
  end

  assign key_down = (a_r[REG_W-1:REG_IDX_W] == '0) && key_r[a_r[REG_IDX_W-1:0]];

  always_comb begin
    single_step = STEP_NEXT;
    case (cmd_r)
      CMD_KEY: begin
        if ((sub_r == K_SKIP_DOWN) && key_down) begin
          single_step = STEP_SKIP;
        end else if ((sub_r == K_SKIP_UP) && !key_down) begin
          single_step = STEP_SKIP;
        end
      end
      CMD_MISC: begin
        if ((sub_r == F_WAIT_KEY) && !any_key) begin
          single_step = STEP_WAIT;
        end
      end
      default: single_step = STEP_NEXT;
    endcase
  end

  // register file write port
  always_comb begin
    we    = 1'b0;
    waddr = x_r;
    wdata = alu_res;
    case (ctrl.wr_sel)
      WR_ALU: we = go && alu_wr;
      WR_FLAG: begin
        we    = go;
        waddr = FLAG_REG;
        wdata = {{(REG_W-1){1'b0}}, alu_flag};
      end
      WR_FMISC: begin
        if (sub_r == F_GET_DELAY) begin
          we    = go;
          wdata = delay_r;
        end else if (sub_r == F_WAIT_KEY) begin
          we    = go && any_key;
          wdata = {{(REG_W-REG_IDX_W){1'b0}}, low_key};
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    vld_nxt = vld_r;
    if (we) begin
      vld_nxt[waddr] = 1'b1;
    end
  end

  // index, timers and store counter
  always_comb begin
    index_nxt = index_r;
    delay_nxt = delay_r;
    sound_nxt = sound_r;
    if (go && ctrl.fmisc) begin
      case (sub_r)
        F_SET_DELAY: delay_nxt = a_r;
        F_SET_SOUND: sound_nxt = a_r;
        F_ADD_INDEX: index_nxt = index_r + INDEX_W'(a_r);
        F_FONT:      index_nxt = INDEX_W'(a_r) * FONT_BYTES;
        F_LOAD:      index_nxt = index_r + INDEX_W'(x_r);
        default:     index_nxt = index_r;
      endcase
    end
    if (go && ctrl.idx_add_x) begin
      index_nxt = index_r + INDEX_W'(x_r);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (go && ctrl.cnt_clr) begin
      cnt_nxt = '0;
    end else if (go && ctrl.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign store_last = (cnt_r == x_r);

  // result word
  assign bcd = bcd_digits(a_r);

  always_comb begin
    o_wr   = 1'b1;
    o_off  = '0;
    o_data = '0;
    o_step = STEP_WAIT;
    o_last = 1'b0;
    case (ctrl.emit)
      EM_BCD0: o_data = {4'd0, bcd[11:8]};
      EM_BCD1: begin
        o_off  = REG_IDX_W'(1);
        o_data = {4'd0, bcd[7:4]};
      end
      EM_BCD2: begin
        o_off  = REG_IDX_W'(2);
        o_data = {4'd0, bcd[3:0]};
        o_step = STEP_NEXT;
        o_last = 1'b1;
      end
      EM_STORE: begin
        o_off  = cnt_r;
        o_data = rd_val;
        o_step = store_last ? STEP_NEXT : STEP_WAIT;
        o_last = store_last;
      end
      default: begin
        o_wr   = 1'b0;
        o_step = single_step;
        o_last = 1'b1;
      end
    endcase
  end

  // addresses wrap at the memory size; only the low bits leave the block
  assign addr_sum = index_r + INDEX_W'(o_off);

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (go && (ctrl.emit != EM_NONE)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r     <= '0;
      delay_r     <= '0;
      sound_r     <= '0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      index_r     <= index_nxt;
      delay_r     <= delay_nxt;
      sound_r     <= sound_nxt;
      vld_r       <= vld_nxt;
      rd_vld_r    <= vld_r[raddr];
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (accept) begin
      cmd_r <= in_command;
      sub_r <= in_sub_op;
      x_r   <= in_reg_x;
      key_r <= in_keypad;
    end
    if (go && ctrl.ld_a) begin
      a_r <= rd_val;
    end
    if (go && ctrl.ld_b) begin
      b_r <= rd_val;
    end
    if (go && (ctrl.emit != EM_NONE)) begin
      out_mem_write   <= o_wr;
      out_mem_address <= o_wr ? addr_sum[ADDR_W-1:0] : '0;
      out_mem_data    <= o_data;
      out_pc_step     <= o_step;
      out_last        <= o_last;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    stat.cmd        = cmd_r;
    stat.sub        = sub_r;
    stat.flag_op    = (cmd_r == CMD_ALU) &&
                      (sub_r[3:0] inside {ALU_ADD, ALU_SUB, ALU_SHR, ALU_RSUB, ALU_SHL});
    stat.store_last = store_last;
    stat.out_free   = out_free;
  end

endmodule

### src/chip8_register_execute_unit.sv
// Top level of the CHIP-8 register execute unit (groups 8, E and F).
//
// Executes one decoded instruction at a time against its own sixteen 8-bit
// registers, 16-bit index and delay/sound values. A small microprogram steps
// a datapath built around a register file with one registered read port, so
// operands are fetched one per cycle. After Vy and Vx are read, key skips
// and FxKK register/timer/index ops finish in a result step; 8xyN writes Vx
// in an ALU step (a flag-setting op writes VF in a later flag step); Fx33
// gives its three writes from the BCD steps and Fx55 loops a read step and
// an emit step per stored byte. A new word is accepted once the last result
// is in the output register, even while that result still waits. Every
// result carries a pc_step; it is final only on the word with last set.
module chip8_register_execute_unit import c8reu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_command,
  input  logic [7:0]           in_sub_op,
  input  logic [REG_IDX_W-1:0] in_reg_x,
  input  logic [REG_IDX_W-1:0] in_reg_y,
  input  logic [KEY_COUNT-1:0] in_keypad,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_mem_write,
  output logic [ADDR_W-1:0]    out_mem_address,
  output logic [7:0]           out_mem_data,
  output logic [1:0]           out_pc_step,
  output logic                 out_last
);

  ctrl_t ctrl;
  stat_t stat;
  logic  go;

  c8reu_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .ctrl    (ctrl),
    .go      (go)
  );

  c8reu_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_command     (in_command),
    .in_sub_op      (in_sub_op),
    .in_reg_x       (in_reg_x),
    .in_reg_y       (in_reg_y),
    .in_keypad      (in_keypad),
    .ctrl           (ctrl),
    .go             (go),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mem_write  (out_mem_write),
    .out_mem_address(out_mem_address),
    .out_mem_data   (out_mem_data),
    .out_pc_step    (out_pc_step),
    .out_last       (out_last)
  );

endmodule
